@@ rtl/id3fw_pkg.sv @@
// id3fw_pkg: shared types and constants of the id3v2 frame walker
// depends on nothing; imported by every module of the block
`default_nettype none

package id3fw_pkg;

    // byte classification codes
    localparam logic [2:0] KIND_TAG_HDR   = 3'd0;
    localparam logic [2:0] KIND_EXT_HDR   = 3'd1;
    localparam logic [2:0] KIND_FRAME_HDR = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd3;
    localparam logic [2:0] KIND_OUTSIDE   = 3'd4;

    // configuration register indexes
    localparam int          CFG_IDX_W      = 1;
    localparam logic [0:0]  CFG_WANTED_ID  = 1'b0;
    localparam logic [0:0]  CFG_PREVIEW    = 1'b1;
    localparam logic [15:0] PREVIEW_RESET  = 16'd50;

    // header geometry
    localparam logic [3:0]  HDR_LAST       = 4'd9;
    localparam logic [28:0] HDR_LEN        = 29'd10;
    localparam logic [28:0] POS_MAX        = 29'h1FFF_FFFF;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    // one classified word handed from front to back
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame_id;
        logic [27:0] frame_size;
        logic [27:0] payload_offset;
        logic        last_of_frame;
        logic [27:0] tag_body_size;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
    } t_walk_rec;

    // configuration write group
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } t_cfg_wr;

endpackage

`default_nettype wire

@@ rtl/id3fw_front.sv @@
// id3fw_front: walker state, classifies each accepted byte into a record
// depends on id3fw_pkg; feeds id3fw_queue
`default_nettype none

module id3fw_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_file_start,
    output id3fw_pkg::t_walk_rec      o_rec
);
    import id3fw_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_EXT     = 3'd1,
        PH_FRAME   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_DONE    = 3'd4
    } t_phase;

    t_phase      r_phase,      n_phase,      cur_phase;
    logic [3:0]  r_phase_count, n_phase_count, cur_count;
    logic [28:0] r_file_pos,   n_file_pos,   cur_pos;
    logic [27:0] r_tag_size,   n_tag_size,   cur_tag_size;
    logic        r_ext_flag,   n_ext_flag,   cur_ext_flag;
    logic [15:0] r_version,    n_version,    cur_version;
    logic [31:0] r_frame_id,   n_frame_id,   cur_frame_id;
    logic [27:0] r_frame_size, n_frame_size, cur_frame_size;
    logic [27:0] r_pay_count,  n_pay_count,  cur_pay_count;

    logic [28:0] tag_end;
    logic [28:0] pay_next;
    logic        pay_last;

    function automatic logic id_char_ok(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // restart view of the state
    always_comb begin
        cur_phase      = i_file_start ? PH_TAG : r_phase;
        cur_count      = i_file_start ? 4'd0   : r_phase_count;
        cur_pos        = i_file_start ? 29'd0  : r_file_pos;
        cur_tag_size   = i_file_start ? 28'd0  : r_tag_size;
        cur_ext_flag   = i_file_start ? 1'b0   : r_ext_flag;
        cur_version    = i_file_start ? 16'd0  : r_version;
        cur_frame_id   = i_file_start ? 32'd0  : r_frame_id;
        cur_frame_size = i_file_start ? 28'd0  : r_frame_size;
        cur_pay_count  = i_file_start ? 28'd0  : r_pay_count;
    end

    assign tag_end  = {1'b0, cur_tag_size} + HDR_LEN;
    assign pay_next = {1'b0, cur_pay_count} + 29'd1;
    assign pay_last = (pay_next >= {1'b0, cur_frame_size});

    // byte classification and next state
    always_comb begin
        n_phase       = cur_phase;
        n_phase_count = cur_count;
        n_tag_size    = cur_tag_size;
        n_ext_flag    = cur_ext_flag;
        n_version     = cur_version;
        n_frame_id    = cur_frame_id;
        n_frame_size  = cur_frame_size;
        n_pay_count   = cur_pay_count;
        n_file_pos    = (cur_pos < POS_MAX) ? cur_pos + 29'd1 : cur_pos;

        o_rec = '0;
        o_rec.kind = KIND_OUTSIDE;

        unique case (cur_phase)
            PH_TAG: begin
                o_rec.kind = KIND_TAG_HDR;
                if (cur_count == 4'd3) begin
                    n_version = {i_data_byte, cur_version[7:0]};
                end else if (cur_count == 4'd4) begin
                    n_version = {cur_version[15:8], i_data_byte};
                end else if (cur_count == 4'd5) begin
                    n_ext_flag = i_data_byte[6];
                end else if (cur_count >= 4'd6) begin
                    n_tag_size = {cur_tag_size[20:0], i_data_byte[6:0]};
                end
                if (cur_count >= HDR_LAST) begin
                    n_phase_count = 4'd0;
                    n_phase       = cur_ext_flag ? PH_EXT : PH_FRAME;
                end else begin
                    n_phase_count = cur_count + 4'd1;
                end
            end
            PH_EXT: begin
                o_rec.kind = KIND_EXT_HDR;
                if (cur_count >= HDR_LAST) begin
                    n_phase_count = 4'd0;
                    n_phase       = PH_FRAME;
                end else begin
                    n_phase_count = cur_count + 4'd1;
                end
            end
            PH_FRAME: begin
                if ((cur_count == 4'd0) && (cur_pos >= tag_end)) begin
                    // tag end passed before a new frame header
                    n_phase      = PH_DONE;
                    n_frame_id   = 32'd0;
                    n_frame_size = 28'd0;
                end else begin
                    o_rec.kind = KIND_FRAME_HDR;
                    if (cur_count == 4'd0) begin
                        n_frame_id = {24'd0, i_data_byte};
                    end else if (cur_count < 4'd4) begin
                        n_frame_id = {cur_frame_id[23:0], i_data_byte};
                    end else if (cur_count == 4'd4) begin
                        n_frame_size = {21'd0, i_data_byte[6:0]};
                    end else if (cur_count < 4'd8) begin
                        n_frame_size = {cur_frame_size[20:0], i_data_byte[6:0]};
                    end
                    o_rec.frame_id   = n_frame_id;
                    o_rec.frame_size = n_frame_size;
                    if (cur_count >= HDR_LAST) begin
                        n_phase_count = 4'd0;
                        if (!(id_char_ok(n_frame_id[31:24]) && id_char_ok(n_frame_id[23:16]) &&
                              id_char_ok(n_frame_id[15:8]) && id_char_ok(n_frame_id[7:0])) ||
                            (n_frame_size == 28'd0)) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_phase     = PH_PAYLOAD;
                            n_pay_count = 28'd0;
                        end
                    end else begin
                        n_phase_count = cur_count + 4'd1;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_rec.kind           = KIND_PAYLOAD;
                o_rec.frame_id       = cur_frame_id;
                o_rec.frame_size     = cur_frame_size;
                o_rec.payload_offset = cur_pay_count;
                o_rec.last_of_frame  = pay_last;
                if (pay_last) begin
                    n_phase       = PH_FRAME;
                    n_phase_count = 4'd0;
                    n_pay_count   = 28'd0;
                end else begin
                    n_pay_count = pay_next[27:0];
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        o_rec.tag_body_size = n_tag_size;
        o_rec.version_major = n_version[15:8];
        o_rec.version_minor = n_version[7:0];
    end

    // walker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_TAG;
            r_phase_count <= 4'd0;
            r_file_pos    <= 29'd0;
            r_tag_size    <= 28'd0;
            r_ext_flag    <= 1'b0;
            r_version     <= 16'd0;
            r_frame_id    <= 32'd0;
            r_frame_size  <= 28'd0;
            r_pay_count   <= 28'd0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_phase_count <= n_phase_count;
            r_file_pos    <= n_file_pos;
            r_tag_size    <= n_tag_size;
            r_ext_flag    <= n_ext_flag;
            r_version     <= n_version;
            r_frame_id    <= n_frame_id;
            r_frame_size  <= n_frame_size;
            r_pay_count   <= n_pay_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase_count <= HDR_LAST)
        else $error("header byte count out of range");

    a_payload_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_pay_count < r_frame_size))
        else $error("payload index reached frame size");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_file_start && (r_file_pos != POS_MAX))
        |=> (r_file_pos == $past(r_file_pos) + 29'd1))
        else $error("file position did not advance");
`endif

endmodule

`default_nettype wire

@@ rtl/id3fw_queue.sv @@
// id3fw_queue: short register queue of classified words between front and back
// depends on id3fw_pkg
`default_nettype none

module id3fw_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire id3fw_pkg::t_walk_rec i_rec,
    input  wire logic                 i_pop,
    output id3fw_pkg::t_walk_rec      o_rec,
    output logic                      o_empty,
    output logic                      o_full
);
    import id3fw_pkg::*;

    t_walk_rec         r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_rec   = r_slot[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_rec;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QPTR_W+1)'(QDEPTH))
        else $error("queue fill count beyond depth");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

    a_fill_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count did not rise on push");
`endif

endmodule

`default_nettype wire

@@ rtl/id3fw_back.sv @@
// id3fw_back: configuration registers, preview and match marks, output register
// depends on id3fw_pkg; drains id3fw_queue
`default_nettype none

module id3fw_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire id3fw_pkg::t_cfg_wr   i_cfg,
    input  wire id3fw_pkg::t_walk_rec i_rec,
    input  wire logic                 i_rec_avail,
    output logic                      o_pop,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [2:0]                o_byte_kind,
    output logic [31:0]               o_current_frame_id,
    output logic [27:0]               o_current_frame_size,
    output logic [27:0]               o_payload_offset,
    output logic                      o_shown,
    output logic                      o_truncated,
    output logic                      o_id_match,
    output logic                      o_last_of_frame,
    output logic [27:0]               o_tag_body_size,
    output logic [7:0]                o_version_major,
    output logic [7:0]                o_version_minor
);
    import id3fw_pkg::*;

    logic [31:0] r_wanted_id;
    logic [15:0] r_preview_limit;

    logic        r_out_valid;
    t_walk_rec   r_rec;
    logic        r_shown, r_trunc, r_match;
    logic        n_shown, n_trunc, n_match;
    logic        is_payload;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_id     <= 32'd0;
            r_preview_limit <= PREVIEW_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_WANTED_ID: r_wanted_id     <= i_cfg.data;
                CFG_PREVIEW:   r_preview_limit <= i_cfg.data[15:0];
                default:       r_wanted_id     <= r_wanted_id;
            endcase
        end
    end

    // take the next word when the output register is free or being taken
    assign o_pop = i_rec_avail && (!r_out_valid || !i_out_stall);

    // payload marks
    assign is_payload = (i_rec.kind == KIND_PAYLOAD);
    assign n_shown = is_payload && (i_rec.payload_offset < {12'd0, r_preview_limit});
    assign n_trunc = is_payload && (i_rec.frame_size > {12'd0, r_preview_limit});
    assign n_match = is_payload && (i_rec.frame_id == r_wanted_id);

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec   <= i_rec;
            r_shown <= n_shown;
            r_trunc <= n_trunc;
            r_match <= n_match;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_byte_kind          = r_rec.kind;
    assign o_current_frame_id   = r_rec.frame_id;
    assign o_current_frame_size = r_rec.frame_size;
    assign o_payload_offset     = r_rec.payload_offset;
    assign o_shown              = r_shown;
    assign o_truncated          = r_trunc;
    assign o_id_match           = r_match;
    assign o_last_of_frame      = r_rec.last_of_frame;
    assign o_tag_body_size      = r_rec.tag_body_size;
    assign o_version_major      = r_rec.version_major;
    assign o_version_minor      = r_rec.version_minor;

`ifndef NO_ASSERTIONS
    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_out_valid)
        else $error("output register empty after pop");

    a_marks_payload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_rec.kind != KIND_PAYLOAD))
        |-> (!r_shown && !r_trunc && !r_match && !r_rec.last_of_frame))
        else $error("payload mark on a non-payload word");

    a_no_pop_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_pop)
        else $error("output register overwritten while stalled");
`endif

endmodule

`default_nettype wire

@@ rtl/id3v2_frame_walker_top.sv @@
// id3v2_frame_walker_top: top level of the id3v2 tag frame walker
// depends on id3fw_pkg, id3fw_front, id3fw_queue, id3fw_back
//
//   channel   direction  handshake                  word
//   input     in         i_in_valid / o_in_stall    i_data_byte, i_file_start
//   result    out        o_out_valid / i_out_stall  byte kind, frame fields, marks
//   config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one byte per cycle sustained while the output is not stalled; each byte gives exactly one result word
// a byte is classified in the cycle it is accepted and its word is registered in the
// queue and then in the output register; a two-word queue sits between front and back
// reset is synchronous and active low and restores the tag header phase
// an output stall fills the queue, after which the input is stalled
`default_nettype none

module id3v2_frame_walker_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [7:0]                     i_data_byte,
    input  wire logic                           i_file_start,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [2:0]                          o_byte_kind,
    output logic [31:0]                         o_current_frame_id,
    output logic [27:0]                         o_current_frame_size,
    output logic [27:0]                         o_payload_offset,
    output logic                                o_shown,
    output logic                                o_truncated,
    output logic                                o_id_match,
    output logic                                o_last_of_frame,
    output logic [27:0]                         o_tag_body_size,
    output logic [7:0]                          o_version_major,
    output logic [7:0]                          o_version_minor,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [id3fw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data
);
    import id3fw_pkg::*;

    t_walk_rec front_rec;
    t_walk_rec head_rec;
    t_cfg_wr   cfg_wr;
    logic      in_accept;
    logic      q_empty, q_full, q_pop;

    // input handshake
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // configuration is always taken
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    id3fw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_rec        (front_rec)
    );

    id3fw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_rec   (front_rec),
        .i_pop   (q_pop),
        .o_rec   (head_rec),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    id3fw_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg_wr),
        .i_rec                (head_rec),
        .i_rec_avail          (!q_empty),
        .o_pop                (q_pop),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_byte_kind          (o_byte_kind),
        .o_current_frame_id   (o_current_frame_id),
        .o_current_frame_size (o_current_frame_size),
        .o_payload_offset     (o_payload_offset),
        .o_shown              (o_shown),
        .o_truncated          (o_truncated),
        .o_id_match           (o_id_match),
        .o_last_of_frame      (o_last_of_frame),
        .o_tag_body_size      (o_tag_body_size),
        .o_version_major      (o_version_major),
        .o_version_minor      (o_version_minor)
    );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// testbench: self-checking bench for id3v2_frame_walker_top
// depends on id3fw_pkg and the frame walker rtl; streams id3v2 tags byte by byte,
// predicts every result word and compares it field by field as it leaves the block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import id3fw_pkg::*;

    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int HOLD_CYCLES       = 300;
    localparam int BYTES_PER_SETTING = 200;
    localparam int PRESSURE_BYTES    = 160;
    localparam int DRAIN_CYCLES      = 4;
    localparam int MAX_REPORTS       = 40;

    localparam logic [7:0]  CHAR_0  = "0";
    localparam logic [7:0]  CHAR_9  = "9";
    localparam logic [7:0]  CHAR_A  = "A";
    localparam logic [7:0]  CHAR_Z  = "Z";
    localparam logic [31:0] ID_TIT2 = "TIT2";
    localparam logic [31:0] ID_TALB = "TALB";

    typedef enum logic [2:0] {
        WALK_TAG, WALK_EXT, WALK_FRAME, WALK_PAYLOAD, WALK_DONE
    } t_walk_phase;

    // one result word, fields in port order
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] frame_id;
        logic [27:0] frame_size;
        logic [27:0] payload_offset;
        logic        shown;
        logic        truncated;
        logic        id_match;
        logic        last_of_frame;
        logic [27:0] tag_body_size;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
    } t_byte_result;

    // clock, reset and block inputs
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic [7:0]           i_data_byte  = '0;
    logic                 i_file_start = 1'b0;
    logic                 i_out_stall  = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = CFG_WANTED_ID;
    logic [31:0]          i_cfg_data   = '0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_byte_kind;
    logic [31:0] o_current_frame_id;
    logic [27:0] o_current_frame_size;
    logic [27:0] o_payload_offset;
    logic        o_shown;
    logic        o_truncated;
    logic        o_id_match;
    logic        o_last_of_frame;
    logic [27:0] o_tag_body_size;
    logic [7:0]  o_version_major;
    logic [7:0]  o_version_minor;
    logic        o_cfg_ready;

    // walker state as predicted, held at its reset values to begin with
    t_walk_phase walk_phase    = WALK_TAG;
    logic [3:0]  hdr_count     = '0;
    logic [28:0] file_pos      = '0;
    logic [27:0] tag_size      = '0;
    logic        ext_flag      = 1'b0;
    logic [15:0] version       = '0;
    logic [31:0] cur_id        = '0;
    logic [27:0] cur_size      = '0;
    logic [27:0] payload_count = '0;
    logic [31:0] wanted_id     = '0;
    logic [15:0] preview_limit = PREVIEW_RESET;

    t_byte_result expected_words[$];
    logic [7:0]   file_bytes[$];

    int mismatches     = 0;
    int words_checked  = 0;
    int idle_cycles    = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    id3v2_frame_walker_top DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_data_byte          (i_data_byte),
        .i_file_start         (i_file_start),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_byte_kind          (o_byte_kind),
        .o_current_frame_id   (o_current_frame_id),
        .o_current_frame_size (o_current_frame_size),
        .o_payload_offset     (o_payload_offset),
        .o_shown              (o_shown),
        .o_truncated          (o_truncated),
        .o_id_match           (o_id_match),
        .o_last_of_frame      (o_last_of_frame),
        .o_tag_body_size      (o_tag_body_size),
        .o_version_major      (o_version_major),
        .o_version_minor      (o_version_minor),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit is_id_char(input logic [7:0] c);
        return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_A && c <= CHAR_Z);
    endfunction

    function automatic bit id_valid(input logic [31:0] id);
        return is_id_char(id[31:24]) && is_id_char(id[23:16]) &&
               is_id_char(id[15:8]) && is_id_char(id[7:0]);
    endfunction

    // advance the predicted walker by one byte and return the word it gives
    function automatic t_byte_result walk_byte(input logic [7:0] b, input logic restart);
        t_byte_result r;
        logic [3:0]   c;
        r      = '0;
        r.kind = KIND_OUTSIDE;
        // a file start wipes the walk but keeps the registers
        if (restart) begin
            walk_phase    = WALK_TAG;
            hdr_count     = '0;
            file_pos      = '0;
            tag_size      = '0;
            ext_flag      = 1'b0;
            version       = '0;
            cur_id        = '0;
            cur_size      = '0;
            payload_count = '0;
        end
        c = hdr_count;
        case (walk_phase)
            WALK_TAG: begin
                r.kind = KIND_TAG_HDR;
                if (c == 4'd3) version[15:8] = b;
                else if (c == 4'd4) version[7:0] = b;
                else if (c == 4'd5) ext_flag = b[6];
                else if (c >= 4'd6) tag_size = {tag_size[20:0], b[6:0]};
                if (c >= HDR_LAST) begin
                    hdr_count  = '0;
                    walk_phase = ext_flag ? WALK_EXT : WALK_FRAME;
                end else begin
                    hdr_count = c + 4'd1;
                end
            end
            WALK_EXT: begin
                r.kind = KIND_EXT_HDR;
                if (c >= HDR_LAST) begin
                    hdr_count  = '0;
                    walk_phase = WALK_FRAME;
                end else begin
                    hdr_count = c + 4'd1;
                end
            end
            WALK_FRAME: begin
                // tag end is only looked at where a frame header would start
                if (c == 4'd0 && {3'b0, file_pos} >= {4'b0, tag_size} + {3'b0, HDR_LEN}) begin
                    walk_phase = WALK_DONE;
                    cur_id     = '0;
                    cur_size   = '0;
                end else begin
                    r.kind = KIND_FRAME_HDR;
                    if (c == 4'd0) cur_id = {24'b0, b};
                    else if (c < 4'd4) cur_id = {cur_id[23:0], b};
                    else if (c == 4'd4) cur_size = {21'b0, b[6:0]};
                    else if (c < 4'd8) cur_size = {cur_size[20:0], b[6:0]};
                    r.frame_id   = cur_id;
                    r.frame_size = cur_size;
                    if (c >= HDR_LAST) begin
                        hdr_count = '0;
                        if (!id_valid(cur_id) || cur_size == '0) begin
                            walk_phase = WALK_DONE;
                        end else begin
                            walk_phase    = WALK_PAYLOAD;
                            payload_count = '0;
                        end
                    end else begin
                        hdr_count = c + 4'd1;
                    end
                end
            end
            WALK_PAYLOAD: begin
                r.kind           = KIND_PAYLOAD;
                r.frame_id       = cur_id;
                r.frame_size     = cur_size;
                r.payload_offset = payload_count;
                r.shown          = payload_count < {12'b0, preview_limit};
                r.truncated      = cur_size > {12'b0, preview_limit};
                r.id_match       = cur_id == wanted_id;
                r.last_of_frame  = ({4'b0, payload_count} + 32'd1) >= {4'b0, cur_size};
                if (r.last_of_frame) begin
                    walk_phase    = WALK_FRAME;
                    hdr_count     = '0;
                    payload_count = '0;
                end else begin
                    payload_count = payload_count + 28'd1;
                end
            end
            default: walk_phase = WALK_DONE;
        endcase
        if (file_pos != POS_MAX) file_pos = file_pos + 29'd1;
        r.tag_body_size = tag_size;
        r.version_major = version[15:8];
        r.version_minor = version[7:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch at %0t ns, word %0d: %s", $time, words_checked, msg);
    endtask

    task automatic field_check(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
    endtask

    // monitor: result words, accepted bytes, register writes and the watchdog
    always @(posedge i_clk) begin : monitor
        t_byte_result got;
        t_byte_result want;
        bit           moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                moved = 1'b1;
                got = {o_byte_kind, o_current_frame_id, o_current_frame_size,
                       o_payload_offset, o_shown, o_truncated, o_id_match,
                       o_last_of_frame, o_tag_body_size, o_version_major,
                       o_version_minor};
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_words.pop_front();
                    field_check("byte_kind", got.kind, want.kind);
                    field_check("current_frame_id", got.frame_id, want.frame_id);
                    field_check("current_frame_size", got.frame_size, want.frame_size);
                    field_check("payload_offset", got.payload_offset, want.payload_offset);
                    field_check("shown", got.shown, want.shown);
                    field_check("truncated", got.truncated, want.truncated);
                    field_check("id_match", got.id_match, want.id_match);
                    field_check("last_of_frame", got.last_of_frame, want.last_of_frame);
                    field_check("tag_body_size", got.tag_body_size, want.tag_body_size);
                    field_check("version_major", got.version_major, want.version_major);
                    field_check("version_minor", got.version_minor, want.version_minor);
                end
                words_checked++;
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                moved = 1'b1;
                expected_words.push_back(walk_byte(i_data_byte, i_file_start));
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                moved = 1'b1;
                if (i_cfg_index == CFG_WANTED_ID) wanted_id = i_cfg_data;
                else preview_limit = i_cfg_data[15:0];
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("testbench failed");
            $finish;
        end
    end

    // output side: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // offer one byte, after a random gap, and hold it until it is taken
    task automatic send_byte(input logic [7:0] value, input logic first);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= value;
        i_file_start <= first;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_file();
        foreach (file_bytes[k]) send_byte(file_bytes[k], k == 0);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // write both registers back to back; only called with the block idle
    task automatic configure(input logic [31:0] want_id, input logic [15:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_WANTED_ID;
        i_cfg_data  <= want_id;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_index <= CFG_PREVIEW;
        i_cfg_data  <= {16'($urandom), limit};
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_word(input logic [31:0] w);
        file_bytes.push_back(w[31:24]);
        file_bytes.push_back(w[23:16]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
    endtask

    // syncsafe encoding, with optional junk in the top bit of each byte
    function automatic logic [31:0] syncsafe(input logic [27:0] s, input logic [3:0] junk);
        return {junk[3], s[27:21], junk[2], s[20:14], junk[1], s[13:7], junk[0], s[6:0]};
    endfunction

    function automatic logic [7:0] rand_id_char();
        int k;
        k = $urandom_range(35);
        return (k < 10) ? CHAR_0 + 8'(k) : CHAR_A + 8'(k - 10);
    endfunction

    function automatic logic [31:0] rand_valid_id();
        return {rand_id_char(), rand_id_char(), rand_id_char(), rand_id_char()};
    endfunction

    function automatic logic [7:0] bad_id_char();
        logic [7:0] c;
        do c = 8'($urandom); while (is_id_char(c));
        return c;
    endfunction

    // one random file: mostly a well formed tag with random content,
    // sometimes broken frames, wrong tag sizes, cut short or plain noise
    task automatic build_random_file();
        int          pick, fsize, body_len, tag_len, cut;
        logic [31:0] fid, size_word;
        logic [7:0]  flags;
        bit          parse_over;
        file_bytes.delete();
        if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(5, 40)) file_bytes.push_back(8'($urandom));
            return;
        end
        // tag header, size patched in once the body is known
        if ($urandom_range(9) != 0)
            push_word({"ID3", ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(2, 4))});
        else
            push_word($urandom);
        file_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'd0);
        flags    = 8'($urandom);
        flags[6] = ($urandom_range(99) < 30);
        file_bytes.push_back(flags);
        push_word('0);
        if (flags[6]) repeat (10) file_bytes.push_back(8'($urandom));
        // frames, until one of them ends the parse
        parse_over = 1'b0;
        repeat ($urandom_range(1, 5)) begin
            if (!parse_over) begin
                pick = $urandom_range(99);
                if (pick < 25) begin
                    fid = wanted_id;
                end else begin
                    fid = rand_valid_id();
                    if (pick >= 92) fid[8*$urandom_range(3) +: 8] = bad_id_char();
                end
                pick  = $urandom_range(99);
                fsize = (pick < 6) ? 0 : (pick < 92) ? $urandom_range(1, 24)
                                                     : $urandom_range(41, 160);
                push_word(fid);
                push_word(syncsafe(28'(fsize), 4'($urandom) & 4'($urandom) & 4'($urandom)));
                file_bytes.push_back(8'($urandom));
                file_bytes.push_back(8'($urandom));
                repeat (fsize) file_bytes.push_back(8'($urandom));
                parse_over = !id_valid(fid) || fsize == 0;
            end
        end
        repeat ($urandom_range(0, 6)) file_bytes.push_back(8'd0);
        body_len = file_bytes.size() - 10;
        tag_len  = ($urandom_range(9) < 7) ? body_len : body_len + $urandom_range(0, 40) - 20;
        if (tag_len < 0) tag_len = 0;
        size_word = syncsafe(28'(tag_len), 4'($urandom) & 4'($urandom) & 4'($urandom));
        for (int k = 0; k < 4; k++) file_bytes[6 + k] = size_word[31 - 8*k -: 8];
        // bytes past the tag
        repeat ($urandom_range(0, 5)) file_bytes.push_back(8'($urandom));
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end
    endtask

    task automatic send_random_bytes(input int amount);
        int sent;
        sent = 0;
        while (sent < amount) begin
            build_random_file();
            sent += file_bytes.size();
            send_file();
        end
    endtask

    // hand-built files for the corner cases, with registers at reset values
    task automatic test_directed();
        send_gap_pct   = 22;
        recv_stall_pct = 60;
        // extended header, size bytes with bit 7 set, id character bounds, bad id
        file_bytes.delete();
        push_word({"ID3", 8'd4});
        file_bytes.push_back(8'd0);
        file_bytes.push_back(8'h40);
        push_word(syncsafe(28'd40, 4'hF));
        repeat (10) file_bytes.push_back(8'($urandom));
        push_word("0A9Z");
        push_word(syncsafe(28'd3, 4'h0));
        push_word({8'h00, 8'h00, 8'h00, 8'hFF});
        file_bytes.push_back(8'h80);
        push_word("/:@[");
        push_word(syncsafe(28'd5, 4'h0));
        push_word({8'hFF, 8'hFF, 8'h5A, 8'h30});
        send_file();
        // all-ones header and frame size, then a restart in the middle of the payload
        file_bytes.delete();
        push_word('1);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'hBF);
        push_word('1);
        push_word("ZZZZ");
        push_word('1);
        push_word({8'h00, 8'h00, 8'h7F, 8'h01});
        send_file();
        // zero tag size ends the walk at the first frame header
        file_bytes.delete();
        push_word({"ID3", 8'd3});
        file_bytes.push_back(8'd0);
        file_bytes.push_back(8'd0);
        push_word('0);
        file_bytes.push_back(8'h41);
        file_bytes.push_back(8'h42);
        send_file();
        // zero frame size
        file_bytes.delete();
        push_word({"ID3", 8'd3});
        file_bytes.push_back(8'd0);
        file_bytes.push_back(8'd0);
        push_word(syncsafe(28'd20, 4'h0));
        push_word("ABCD");
        push_word('0);
        push_word({8'h00, 8'h00, 8'h54, 8'h49});
        send_file();
        // tag end reached exactly after one frame
        file_bytes.delete();
        push_word({"ID3", 8'd3});
        file_bytes.push_back(8'd0);
        file_bytes.push_back(8'd0);
        push_word(syncsafe(28'd13, 4'h0));
        push_word("A1B2");
        push_word(syncsafe(28'd3, 4'h0));
        push_word({8'h00, 8'h00, 8'h11, 8'h22});
        file_bytes.push_back(8'h33);
        file_bytes.push_back(8'h54);
        send_file();
        wait_drained();
    endtask

    // output held off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_requests++;
        send_random_bytes(PRESSURE_BYTES);
        wait_drained();
    endtask

    // random tags over several register settings and idling patterns
    task automatic test_random_traffic();
        for (int setting = 0; setting < 6; setting++) begin
            send_gap_pct   = (setting < 2) ? 22 : (setting < 4) ? 60 : 0;
            recv_stall_pct = (setting < 2) ? 60 : (setting < 4) ? 22 : 0;
            wait_drained();
            case (setting)
                0:       configure(ID_TIT2, 16'd50);
                1:       configure(32'hFFFF_FFFF, 16'd0);
                2:       configure(rand_valid_id(), 16'hFFFF);
                3:       configure(32'h0, 16'd1);
                4:       configure(ID_TALB, 16'd7);
                default: configure(rand_valid_id(), 16'($urandom_range(0, 100)));
            endcase
            send_random_bytes(BYTES_PER_SETTING);
        end
        wait_drained();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
